/* rtl/core/rmm_pkg.sv */
// ============================================================================
// rmm_pkg: shared types and helper functions for the random math/merge ALU
// Operation codes for the math and merge selectors, plus the narrow
// arithmetic helpers (mod 11, mod 31, leading zeros, population count).
// ============================================================================
`default_nettype none

package rmm_pkg;

  // Math operation selected by math_word mod 11
  typedef enum logic [3:0] {
    MATH_ADD  = 4'd0,
    MATH_MULL = 4'd1,
    MATH_MULH = 4'd2,
    MATH_MIN  = 4'd3,
    MATH_ROTL = 4'd4,
    MATH_ROTR = 4'd5,
    MATH_AND  = 4'd6,
    MATH_OR   = 4'd7,
    MATH_XOR  = 4'd8,
    MATH_CLZ  = 4'd9,
    MATH_POPC = 4'd10
  } math_op_t;

  // Merge operation selected by merge_word mod 4
  typedef enum logic [1:0] {
    MERGE_MULADD = 2'd0,
    MERGE_XORMUL = 2'd1,
    MERGE_ROTL   = 2'd2,
    MERGE_ROTR   = 2'd3
  } merge_op_t;

  // 32-bit word mod 11: fold nibbles by 16^k mod 11, fold again, then
  // finish with a short restoring subtract.
  function automatic logic [3:0] mod11_32(input logic [31:0] x);
    logic [8:0] t;
    logic [6:0] u;
    t = 9'(x[3:0]) + 9'(x[7:4]) * 9'd5 + 9'(x[11:8]) * 9'd3
      + 9'(x[15:12]) * 9'd4 + 9'(x[19:16]) * 9'd9 + 9'(x[23:20])
      + 9'(x[27:24]) * 9'd5 + 9'(x[31:28]) * 9'd3;
    // 256 mod 11 = 3, 16 mod 11 = 5
    u = 7'(t[8]) * 7'd3 + 7'(t[7:4]) * 7'd5 + 7'(t[3:0]);
    if (u >= 7'd88) u = u - 7'd88;
    if (u >= 7'd44) u = u - 7'd44;
    if (u >= 7'd22) u = u - 7'd22;
    if (u >= 7'd11) u = u - 7'd11;
    return u[3:0];
  endfunction

  // 16-bit value mod 31: 32 mod 31 = 1, so sum the 5-bit digits
  function automatic logic [4:0] mod31_16(input logic [15:0] x);
    logic [6:0] t;
    logic [5:0] u;
    t = 7'(x[4:0]) + 7'(x[9:5]) + 7'(x[14:10]) + 7'(x[15]);
    u = 6'(t[6:5]) + 6'(t[4:0]);
    if (u >= 6'd31) u = u - 6'd31;
    return u[4:0];
  endfunction

  // Leading zero count, all-zero word counts as 32
  function automatic logic [5:0] clz32(input logic [31:0] x);
    logic [31:0] v;
    logic [5:0]  n;
    v = x;
    n = '0;
    if (x == '0) begin
      n = 6'd32;
    end else begin
      if (v[31:16] == '0) begin n = n + 6'd16; v = v << 16; end
      if (v[31:24] == '0) begin n = n + 6'd8;  v = v << 8;  end
      if (v[31:28] == '0) begin n = n + 6'd4;  v = v << 4;  end
      if (v[31:30] == '0) begin n = n + 6'd2;  v = v << 2;  end
      if (!v[31])         begin n = n + 6'd1;               end
    end
    return n;
  endfunction

  // Population count: per-nibble counts, then sum of eight nibble counts
  function automatic logic [5:0] popc32(input logic [31:0] x);
    logic [2:0] nib [8];
    logic [5:0] n;
    for (int i = 0; i < 8; i++) begin
      nib[i] = 3'(x[4*i]) + 3'(x[4*i+1]) + 3'(x[4*i+2]) + 3'(x[4*i+3]);
    end
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 6'(nib[i]);
    end
    return n;
  endfunction

  // Rotates by a 5-bit amount; an amount of zero returns the word unchanged
  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} << n;
    return w[63:32];
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} >> n;
    return w[31:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/random_math_merge_alu.sv */
// ============================================================================
// random_math_merge_alu: one random-program math and merge step
// Registers: input register, then result register. Throughput: one beat
// per cycle while out_ready does not stall; the math/merge logic between
// the two registers, led by the 32x32 multiplier, sets the path.
// Reset: synchronous active-low rst_n clears both valid flags; payload
// registers are not reset.
// ============================================================================
`default_nettype none

module random_math_merge_alu (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_cmd,
  input  wire logic [31:0] in_dest_value,
  input  wire logic [31:0] in_operand_a,
  input  wire logic [31:0] in_operand_b,
  input  wire logic [31:0] in_math_word,
  input  wire logic [31:0] in_merge_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_merged_value,
  output logic [31:0]      out_math_value
);
  import rmm_pkg::*;

  // Input register stage
  logic        s1_valid_r;
  logic        cmd_r;
  logic [31:0] dest_r;
  logic [31:0] a_r;
  logic [31:0] b_r;
  logic [31:0] msel_r;
  logic [31:0] gsel_r;

  // Result register stage
  logic        out_valid_r;
  logic [31:0] merged_r;
  logic [31:0] math_r;

  logic        out_adv;
  logic        s1_adv;

  logic [63:0] prod;
  math_op_t    math_op;
  merge_op_t   merge_op;
  logic [4:0]  merge_rot;
  logic [31:0] math_res;
  logic [31:0] data;
  logic [31:0] merged_nxt;
  logic [31:0] dxor;

  // Stage advance: result stage frees when empty or taken downstream
  assign out_adv  = !out_valid_r || out_ready;
  assign s1_adv   = !s1_valid_r || out_adv;
  assign in_ready = s1_adv;

  // Capture input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      cmd_r  <= in_cmd;
      dest_r <= in_dest_value;
      a_r    <= in_operand_a;
      b_r    <= in_operand_b;
      msel_r <= in_math_word;
      gsel_r <= in_merge_word;
    end
  end

  // Decode selectors
  assign math_op   = math_op_t'(mod11_32(msel_r));
  assign merge_op  = merge_op_t'(gsel_r[1:0]);
  assign merge_rot = mod31_16(gsel_r[31:16]) + 5'd1;

  // Full 64-bit product, shared by low and high product ops
  assign prod = {32'd0, a_r} * {32'd0, b_r};

  // Math operation
  always_comb begin
    unique case (math_op)
      MATH_ADD:  math_res = a_r + b_r;
      MATH_MULL: math_res = prod[31:0];
      MATH_MULH: math_res = prod[63:32];
      MATH_MIN:  math_res = (a_r < b_r) ? a_r : b_r;
      MATH_ROTL: math_res = rotl32(a_r, b_r[4:0]);
      MATH_ROTR: math_res = rotr32(a_r, b_r[4:0]);
      MATH_AND:  math_res = a_r & b_r;
      MATH_OR:   math_res = a_r | b_r;
      MATH_XOR:  math_res = a_r ^ b_r;
      MATH_CLZ:  math_res = {25'd0, 7'(clz32(a_r)) + 7'(clz32(b_r))};
      MATH_POPC: math_res = {25'd0, 7'(popc32(a_r)) + 7'(popc32(b_r))};
      default:   math_res = '0;
    endcase
  end

  assign data = cmd_r ? math_res : a_r;
  assign dxor = dest_r ^ data;

  // Merge into destination; times 33 is shift-and-add
  always_comb begin
    unique case (merge_op)
      MERGE_MULADD: merged_nxt = {dest_r[26:0], 5'd0} + dest_r + data;
      MERGE_XORMUL: merged_nxt = {dxor[26:0], 5'd0} + dxor;
      MERGE_ROTL:   merged_nxt = rotl32(dest_r, merge_rot) ^ data;
      MERGE_ROTR:   merged_nxt = rotr32(dest_r, merge_rot) ^ data;
      default:      merged_nxt = '0;
    endcase
  end

  // Result register: advance when downstream takes or slot is empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      merged_r <= merged_nxt;
      math_r   <= data;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_merged_value = merged_r;
  assign out_math_value   = math_r;

  // Reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !s1_valid_r)
    else $error("pipeline not empty after reset");

  // A held input beat always moves into the result stage when it frees
  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_adv |=> out_valid_r)
    else $error("beat lost between stages");

  // Back-pressure only when both stages are full and output is stalled
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled without full pipeline");

  // Merge-only beats pass operand_a through as the math value
  a_cmd0_pass: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_adv && !cmd_r |=> out_math_value == $past(a_r))
    else $error("math value differs from operand_a on merge-only beat");

endmodule

`default_nettype wire

/* bench/math_merge_checker.sv */
`timescale 1ns / 100ps
// ============================================================================
// math_merge_checker: result predictor and comparator for the math/merge ALU
// Watches the input and result channels, computes the merged word and the
// math word of every accepted input beat, and matches result beats in order.
// ============================================================================

module math_merge_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_cmd,
  input  logic [31:0]       in_dest_value,
  input  logic [31:0]       in_operand_a,
  input  logic [31:0]       in_operand_b,
  input  logic [31:0]       in_math_word,
  input  logic [31:0]       in_merge_word,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [31:0]       out_merged_value,
  input  logic [31:0]       out_math_value,
  output int unsigned       mismatches,
  output int unsigned       outstanding
);
  import rmm_pkg::*;

  typedef struct packed {
    logic [31:0] merged_value;
    logic [31:0] math_value;
  } step_result_t;

  step_result_t pending_steps[$];

  // Rotates treat an amount of zero as a plain pass
  function automatic logic [31:0] spin_left(logic [31:0] x, logic [4:0] n);
    if (n == 5'd0) return x;
    return (x << n) | (x >> (6'd32 - 6'(n)));
  endfunction

  function automatic logic [31:0] spin_right(logic [31:0] x, logic [4:0] n);
    if (n == 5'd0) return x;
    return (x >> n) | (x << (6'd32 - 6'(n)));
  endfunction

  // Zero word counts 32 leading zeros
  function automatic logic [31:0] leading_zeros(logic [31:0] x);
    logic [31:0] n;
    n = 32'd0;
    for (int i = 31; i >= 0; i--) begin
      if (x[i]) break;
      n++;
    end
    return n;
  endfunction

  function automatic logic [31:0] set_bits(logic [31:0] x);
    logic [31:0] n;
    n = 32'd0;
    for (int i = 0; i < 32; i++) n += 32'(x[i]);
    return n;
  endfunction

  function automatic logic [31:0] math_result(logic [31:0] a, logic [31:0] b,
                                              logic [31:0] sel);
    math_op_t    op;
    logic [63:0] product;
    op      = math_op_t'(4'(sel % 32'd11));
    product = {32'd0, a} * {32'd0, b};
    case (op)
      MATH_ADD:  return a + b;
      MATH_MULL: return product[31:0];
      MATH_MULH: return product[63:32];
      MATH_MIN:  return (a < b) ? a : b;
      MATH_ROTL: return spin_left(a, b[4:0]);
      MATH_ROTR: return spin_right(a, b[4:0]);
      MATH_AND:  return a & b;
      MATH_OR:   return a | b;
      MATH_XOR:  return a ^ b;
      MATH_CLZ:  return leading_zeros(a) + leading_zeros(b);
      default:   return set_bits(a) + set_bits(b);
    endcase
  endfunction

  // Work out both result fields of one input beat
  function automatic step_result_t predict_step(logic cmd, logic [31:0] dest,
                                                logic [31:0] a, logic [31:0] b,
                                                logic [31:0] msel,
                                                logic [31:0] gsel);
    step_result_t r;
    merge_op_t    op;
    logic [4:0]   amount;
    r.math_value = cmd ? math_result(a, b, msel) : a;
    op     = merge_op_t'(gsel[1:0]);
    amount = 5'(gsel[31:16] % 16'd31) + 5'd1;
    case (op)
      MERGE_MULADD: r.merged_value = dest * 32'd33 + r.math_value;
      MERGE_XORMUL: r.merged_value = (dest ^ r.math_value) * 32'd33;
      MERGE_ROTL:   r.merged_value = spin_left(dest, amount) ^ r.math_value;
      default:      r.merged_value = spin_right(dest, amount) ^ r.math_value;
    endcase
    return r;
  endfunction

  // Match result beats first, then queue the input beat of this edge
  always @(posedge clk) begin : watch
    step_result_t want;
    int unsigned  errs;
    errs = 0;
    if (!rst_n) begin
      pending_steps.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_steps.size() == 0) begin
          $error("result beat with nothing expected: merged_value %h math_value %h",
                 out_merged_value, out_math_value);
          errs++;
        end else begin
          want = pending_steps.pop_front();
          if (out_merged_value !== want.merged_value) begin
            $error("merged_value: expected %h, actual %h",
                   want.merged_value, out_merged_value);
            errs++;
          end
          if (out_math_value !== want.math_value) begin
            $error("math_value: expected %h, actual %h",
                   want.math_value, out_math_value);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_steps.push_back(predict_step(in_cmd, in_dest_value, in_operand_a,
                                             in_operand_b, in_math_word,
                                             in_merge_word));
      end
    end
    mismatches  <= mismatches + errs;
    outstanding <= pending_steps.size();
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ============================================================================
// testbench: regression for the random math/merge ALU
// Drives directed corner beats and then random beats through the input
// channel with random idle and stall bursts; a side checker predicts and
// compares every result beat and reports its mismatch count here.
// ============================================================================

module testbench;
  import rmm_pkg::*;

  localparam int RANDOM_ITEMS = 900;
  localparam int QUIET_ITEMS  = 150;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_cmd;
  logic [31:0] in_dest_value;
  logic [31:0] in_operand_a;
  logic [31:0] in_operand_b;
  logic [31:0] in_math_word;
  logic [31:0] in_merge_word;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_merged_value;
  logic [31:0] out_math_value;
  int unsigned mismatches;
  int unsigned outstanding;
  logic        quiet = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  random_math_merge_alu DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_dest_value    (in_dest_value),
    .in_operand_a     (in_operand_a),
    .in_operand_b     (in_operand_b),
    .in_math_word     (in_math_word),
    .in_merge_word    (in_merge_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_merged_value (out_merged_value),
    .out_math_value   (out_math_value)
  );

  math_merge_checker step_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_dest_value    (in_dest_value),
    .in_operand_a     (in_operand_a),
    .in_operand_b     (in_operand_b),
    .in_math_word     (in_math_word),
    .in_merge_word    (in_merge_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_merged_value (out_merged_value),
    .out_math_value   (out_math_value),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  // Selector word whose value mod 11 is the given math operation
  function automatic logic [31:0] math_sel(math_op_t op);
    return 32'(op) + 32'd11 * $urandom_range(0, 390451571);
  endfunction

  // Merge word with a chosen operation and rotate field
  function automatic logic [31:0] merge_sel(merge_op_t op, logic [15:0] spin);
    logic [31:0] w;
    w        = $urandom;
    w[31:16] = spin;
    w[1:0]   = op;
    return w;
  endfunction

  // Operand with extra weight on zero, all ones, small values and single bits
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return '1;
      2:       return $urandom_range(0, 63);
      3:       return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Present one beat and hold it until accepted
  task automatic push_item(logic cmd, logic [31:0] dest, logic [31:0] a,
                           logic [31:0] b, logic [31:0] msel, logic [31:0] gsel);
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_dest_value <= dest;
    in_operand_a  <= a;
    in_operand_b  <= b;
    in_math_word  <= msel;
    in_merge_word <= gsel;
    do @(posedge clk); while (!in_ready);
  endtask

  // Wait until every expected result beat has come back
  task automatic drain();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Result side: random stall bursts, none in the closing stretch
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  initial begin
    logic [31:0] gsel;
    in_valid      = 1'b0;
    in_cmd        = 1'b0;
    in_dest_value = '0;
    in_operand_a  = '0;
    in_operand_b  = '0;
    in_math_word  = '0;
    in_merge_word = '0;
    rst_n         = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Field extremes
    push_item(1'b0, '0, '0, '0, '0, '0);
    push_item(1'b1, '1, '1, '1, '1, '1);
    // Every math operation with random operands
    for (int k = 0; k <= int'(MATH_POPC); k++) begin
      push_item(1'b1, $urandom, pick_word(), pick_word(), math_sel(math_op_t'(k)),
                $urandom);
    end
    // Leading zeros of zero, rotates by zero, wrapping sum and product
    push_item(1'b1, $urandom, '0, '0, math_sel(MATH_CLZ), $urandom);
    push_item(1'b1, $urandom, $urandom, 32'd0, math_sel(MATH_ROTL), $urandom);
    push_item(1'b1, $urandom, $urandom, 32'd32, math_sel(MATH_ROTR), $urandom);
    push_item(1'b1, $urandom, '1, 32'd1, math_sel(MATH_ADD), $urandom);
    push_item(1'b1, $urandom, '1, '1, math_sel(MATH_MULH), $urandom);
    // Pass-through ignores the math selector and second operand
    push_item(1'b0, $urandom, $urandom, $urandom, math_sel(MATH_MULL), $urandom);
    // Every merge with rotate fields giving shifts of 1, 31 and 2
    push_item(1'b0, '1, $urandom, $urandom, $urandom, merge_sel(MERGE_MULADD, 16'd7));
    push_item(1'b1, '1, $urandom, $urandom, $urandom, merge_sel(MERGE_XORMUL, 16'd0));
    push_item(1'b0, $urandom, $urandom, $urandom, $urandom, merge_sel(MERGE_ROTL, 16'd0));
    push_item(1'b1, $urandom, $urandom, $urandom, $urandom, merge_sel(MERGE_ROTL, 16'd30));
    push_item(1'b0, $urandom, $urandom, $urandom, $urandom, merge_sel(MERGE_ROTR, 16'd31));
    push_item(1'b1, $urandom, $urandom, $urandom, $urandom, merge_sel(MERGE_ROTR, 16'hffff));

    // Random beats with idle bursts; closing stretch runs back to back
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      if (n == 300) begin
        in_valid <= 1'b0;
        drain();
      end
      gsel = $urandom;
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 2))
          0:       gsel[31:16] = 16'd0;
          1:       gsel[31:16] = 16'd30;
          default: gsel[31:16] = 16'hffff;
        endcase
      end
      push_item($urandom_range(0, 4) != 0, pick_word(), pick_word(), pick_word(),
                $urandom, gsel);
    end
    in_valid <= 1'b0;

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("random_math_merge_alu regression: pass");
    end else begin
      $display("random_math_merge_alu regression: fail");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #2ms;
    $display("random_math_merge_alu regression: fail");
    $finish;
  end

endmodule
